// ----- hw/rtl/clpm_pkg.sv -----
// ----------------------------------------------------------------------------
// clpm_pkg
// Shared constants, codes and control types of the cursor list pool manager.
// ----------------------------------------------------------------------------
`default_nettype none

package clpm_pkg;

    localparam int LISTS      = 3;
    localparam int POOL_NODES = 64;
    localparam int ITEM_BITS  = 32;
    localparam int NODE_BITS  = $clog2(POOL_NODES);
    localparam int LINK_BITS  = $clog2(POOL_NODES + 1);
    localparam int LC_BITS    = $clog2(LISTS + 1);

    localparam logic [LINK_BITS-1:0] NO_NODE = LINK_BITS'(POOL_NODES);

    localparam logic [3:0] M_CREATE  = 4'd0;
    localparam logic [3:0] M_COUNT   = 4'd1;
    localparam logic [3:0] M_FIRST   = 4'd2;
    localparam logic [3:0] M_LAST    = 4'd3;
    localparam logic [3:0] M_NEXT    = 4'd4;
    localparam logic [3:0] M_PREV    = 4'd5;
    localparam logic [3:0] M_CURR    = 4'd6;
    localparam logic [3:0] M_ADD     = 4'd7;
    localparam logic [3:0] M_INSERT  = 4'd8;
    localparam logic [3:0] M_APPEND  = 4'd9;
    localparam logic [3:0] M_PREPEND = 4'd10;
    localparam logic [3:0] M_REMOVE  = 4'd11;
    localparam logic [3:0] M_CONCAT  = 4'd12;
    localparam logic [3:0] M_TRIM    = 4'd13;

    localparam logic [1:0] P_AT_NODE     = 2'd0;
    localparam logic [1:0] P_BEFORE_HEAD = 2'd1;
    localparam logic [1:0] P_BEYOND_TAIL = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOLIST = 2'd2;

    typedef enum logic [3:0] {
        OP_END,
        OP_CREATE,
        OP_FIRST_MV,
        OP_LAST_MV,
        OP_NEXT_MV,
        OP_PREV_MV,
        OP_CURR,
        OP_ADD,
        OP_REMOVE,
        OP_JOIN
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RD,
        PH_EX,
        PH_W2,
        PH_FIN
    } t_phase;

    typedef struct packed {
        t_op    op;
        t_phase phase;
        logic   start;
        logic   load_out;
    } t_ctl;

    typedef struct packed {
        logic [3:0] mode;
        logic       bad;
    } t_sts;

    function automatic t_op prog_op(input logic [3:0] mode, input logic [1:0] step);
        t_op op;
        op = OP_END;
        unique case (mode)
            M_CREATE:  op = (step == 2'd0) ? OP_CREATE : OP_END;
            M_FIRST:   op = (step == 2'd0) ? OP_FIRST_MV : (step == 2'd1) ? OP_CURR : OP_END;
            M_LAST:    op = (step == 2'd0) ? OP_LAST_MV : (step == 2'd1) ? OP_CURR : OP_END;
            M_NEXT:    op = (step == 2'd0) ? OP_NEXT_MV : (step == 2'd1) ? OP_CURR : OP_END;
            M_PREV:    op = (step == 2'd0) ? OP_PREV_MV : (step == 2'd1) ? OP_CURR : OP_END;
            M_CURR:    op = (step == 2'd0) ? OP_CURR : OP_END;
            M_ADD:     op = (step == 2'd0) ? OP_ADD : OP_END;
            M_INSERT:  op = (step == 2'd0) ? OP_PREV_MV : (step == 2'd1) ? OP_ADD : OP_END;
            M_APPEND:  op = (step == 2'd0) ? OP_LAST_MV : (step == 2'd1) ? OP_ADD : OP_END;
            M_PREPEND: op = (step == 2'd0) ? OP_FIRST_MV : (step == 2'd1) ? OP_PREV_MV :
                            (step == 2'd2) ? OP_ADD : OP_END;
            M_REMOVE:  op = (step == 2'd0) ? OP_REMOVE : OP_END;
            M_CONCAT:  op = (step == 2'd0) ? OP_JOIN : OP_END;
            M_TRIM:    op = (step == 2'd0) ? OP_LAST_MV : (step == 2'd1) ? OP_REMOVE : OP_END;
            default:   op = OP_END;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/clpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// clpm_ctrl
// Sequencer that walks the operation program of each command and holds the
// output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module clpm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire clpm_pkg::t_sts i_sts,
    output clpm_pkg::t_ctl     o_ctl
);
    import clpm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_W2,
        S_FIN
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    t_op        cur_op;
    logic       load;

    assign cur_op = i_sts.bad ? OP_END : prog_op(i_sts.mode, r_step);
    assign load   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        if (load) begin
            n_out_valid = 1'b1;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RD;
                    n_step  = 2'd0;
                end
            end
            S_RD: begin
                n_state = (cur_op == OP_END) ? S_FIN : S_EX;
            end
            S_EX: begin
                n_state = S_W2;
            end
            S_W2: begin
                n_state = S_RD;
                n_step  = r_step + 2'd1;
            end
            S_FIN: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_ctl.op       = cur_op;
        o_ctl.start    = (r_state == S_IDLE) && i_in_valid;
        o_ctl.load_out = load;
        unique case (r_state)
            S_RD:    o_ctl.phase = (cur_op == OP_END) ? PH_IDLE : PH_RD;
            S_EX:    o_ctl.phase = PH_EX;
            S_W2:    o_ctl.phase = PH_W2;
            S_FIN:   o_ctl.phase = PH_FIN;
            default: o_ctl.phase = PH_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_RD && r_step == 2'd0))
        else $error("command start did not enter the first step");
    a_ex_w2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX) |=> (r_state == S_W2))
        else $error("execute phase not followed by second write phase");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W2) |=> (r_state == S_RD && r_step == $past(r_step) + 2'd1))
        else $error("step counter did not advance");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_out_ready) |=> (r_state == S_FIN))
        else $error("finished command left while output register was full");

endmodule

`default_nettype wire

// ----- hw/rtl/clpm_dpath.sv -----
// ----------------------------------------------------------------------------
// clpm_dpath
// List headers, node link and item memories, free chain and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module clpm_dpath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire clpm_pkg::t_ctl                 i_ctl,
    output clpm_pkg::t_sts                      o_sts,
    input  wire logic [3:0]                     i_mode,
    input  wire logic [1:0]                     i_list_sel,
    input  wire logic [1:0]                     i_other_list,
    input  wire logic [31:0]                    i_item_in,
    output logic [31:0]                         o_item_out,
    output logic                                o_item_valid,
    output logic [1:0]                          o_status,
    output logic [1:0]                          o_new_list,
    output logic [6:0]                          o_item_count,
    output logic [1:0]                          o_cursor_place
);
    import clpm_pkg::*;

    logic [LINK_BITS-1:0] r_head [LISTS];
    logic [LINK_BITS-1:0] r_tail [LISTS];
    logic [LINK_BITS-1:0] r_cur  [LISTS];
    logic [LINK_BITS-1:0] r_len  [LISTS];
    logic [1:0]           r_place[LISTS];
    logic [LINK_BITS-1:0] n_head [LISTS];
    logic [LINK_BITS-1:0] n_tail [LISTS];
    logic [LINK_BITS-1:0] n_cur  [LISTS];
    logic [LINK_BITS-1:0] n_len  [LISTS];
    logic [1:0]           n_place[LISTS];
    logic [LINK_BITS-1:0] r_free, n_free;
    logic [LC_BITS-1:0]   r_created, n_created;

    logic [LINK_BITS-1:0] r_nx_mem [POOL_NODES];
    logic [LINK_BITS-1:0] r_pv_mem [POOL_NODES];
    logic [ITEM_BITS-1:0] r_it_mem [POOL_NODES];
    logic [POOL_NODES-1:0] r_nv, r_pv;

    logic [LINK_BITS-1:0] r_q_nxa, r_q_nxb, r_q_pv;
    logic [ITEM_BITS-1:0] r_q_item;

    logic [3:0]           r_mode;
    logic [1:0]           r_sel, r_oth;
    logic [ITEM_BITS-1:0] r_item;
    logic                 r_bad;
    logic [ITEM_BITS-1:0] r_it, n_it;
    logic                 r_iv, n_iv;
    logic [1:0]           r_status, n_status;
    logic [1:0]           r_newl, n_newl;

    logic                 w1n_en, w1p_en, w1i_en, w2n_en, w2p_en;
    logic [LINK_BITS-1:0] w1n_a, w1n_d, w1p_a, w1p_d, w2n_a, w2n_d, w2p_a, w2p_d;
    logic [LINK_BITS-1:0] w1i_a;
    logic                 r_w2n_en, r_w2p_en;
    logic [LINK_BITS-1:0] r_w2n_a, r_w2n_d, r_w2p_a, r_w2p_d;

    logic                 wn_en, wp_en;
    logic [LINK_BITS-1:0] wn_a, wn_d, wp_a, wp_d;

    logic [NODE_BITS-1:0] ca, fb;
    logic                 bad_in;

    function automatic logic is_created(input logic [1:0] l, input logic [LC_BITS-1:0] cr);
        return (int'(l) < LISTS) && (int'(l) + int'(cr) >= LISTS);
    endfunction

    assign bad_in = (i_mode != M_CREATE) && (!is_created(i_list_sel, r_created) ||
                    (i_mode == M_CONCAT && !is_created(i_other_list, r_created)));

    assign o_sts.mode = r_mode;
    assign o_sts.bad  = r_bad;

    assign ca = r_cur[r_sel][NODE_BITS-1:0];
    assign fb = r_free[NODE_BITS-1:0];

    always_comb begin
        logic [LINK_BITS-1:0] h, t, c, l, nn, a, p, r;
        logic [1:0]           pl;
        logic [1:0]           nl;
        h  = r_head[r_sel];
        t  = r_tail[r_sel];
        c  = r_cur[r_sel];
        l  = r_len[r_sel];
        pl = r_place[r_sel];
        nn = r_free;
        a  = r_q_nxa;
        p  = r_q_pv;
        r  = r_q_nxa;
        nl = 2'(LISTS - 1 - int'(r_created));
        n_head    = r_head;
        n_tail    = r_tail;
        n_cur     = r_cur;
        n_len     = r_len;
        n_place   = r_place;
        n_free    = r_free;
        n_created = r_created;
        n_it      = r_it;
        n_iv      = r_iv;
        n_status  = r_status;
        n_newl    = r_newl;
        w1n_en = 1'b0; w1n_a = '0; w1n_d = '0;
        w1p_en = 1'b0; w1p_a = '0; w1p_d = '0;
        w1i_en = 1'b0; w1i_a = '0;
        w2n_en = 1'b0; w2n_a = '0; w2n_d = '0;
        w2p_en = 1'b0; w2p_a = '0; w2p_d = '0;
        if (i_ctl.phase == PH_EX) begin
            case (i_ctl.op)
                OP_CREATE: begin
                    if (int'(r_created) >= LISTS) begin
                        n_status = ST_FULL;
                    end else begin
                        n_newl         = nl;
                        n_head[nl]     = NO_NODE;
                        n_tail[nl]     = NO_NODE;
                        n_cur[nl]      = NO_NODE;
                        n_len[nl]      = '0;
                        n_place[nl]    = P_AT_NODE;
                        n_created      = r_created + LC_BITS'(1);
                    end
                end
                OP_FIRST_MV: begin
                    if (l != '0) begin
                        n_cur[r_sel]   = h;
                        n_place[r_sel] = P_AT_NODE;
                    end
                end
                OP_LAST_MV: begin
                    if (l != '0) begin
                        n_cur[r_sel]   = t;
                        n_place[r_sel] = P_AT_NODE;
                    end
                end
                OP_NEXT_MV: begin
                    if (l != '0) begin
                        if (r_q_nxa == NO_NODE) begin
                            n_place[r_sel] = P_BEYOND_TAIL;
                        end else begin
                            n_cur[r_sel]   = r_q_nxa;
                            n_place[r_sel] = P_AT_NODE;
                        end
                    end
                end
                OP_PREV_MV: begin
                    if (l != '0) begin
                        if (r_q_pv == NO_NODE) begin
                            n_place[r_sel] = P_BEFORE_HEAD;
                        end else begin
                            n_cur[r_sel]   = r_q_pv;
                            n_place[r_sel] = P_AT_NODE;
                        end
                    end
                end
                OP_CURR: begin
                    if (l != '0 && pl == P_AT_NODE) begin
                        n_it = r_q_item;
                        n_iv = 1'b1;
                    end
                end
                OP_ADD: begin
                    if (nn == NO_NODE) begin
                        n_status = ST_FULL;
                    end else begin
                        n_free = r_q_nxb;
                        w1i_en = 1'b1;
                        w1i_a  = nn;
                        w1n_en = 1'b1;
                        w1n_a  = nn;
                        w1p_en = 1'b1;
                        w1p_a  = nn;
                        if (l == '0) begin
                            w1n_d         = NO_NODE;
                            w1p_d         = NO_NODE;
                            n_head[r_sel] = nn;
                            n_tail[r_sel] = nn;
                        end else if (pl == P_BEFORE_HEAD) begin
                            w1n_d         = h;
                            w1p_d         = NO_NODE;
                            w2p_en        = (h != NO_NODE);
                            w2p_a         = h;
                            w2p_d         = nn;
                            n_head[r_sel] = nn;
                        end else if (pl == P_BEYOND_TAIL) begin
                            w1n_d         = NO_NODE;
                            w1p_d         = t;
                            w2n_en        = (t != NO_NODE);
                            w2n_a         = t;
                            w2n_d         = nn;
                            n_tail[r_sel] = nn;
                        end else begin
                            w1n_d  = a;
                            w1p_d  = c;
                            w2p_en = (a != NO_NODE);
                            w2p_a  = a;
                            w2p_d  = nn;
                            w2n_en = (c != NO_NODE);
                            w2n_a  = c;
                            w2n_d  = nn;
                            if (a == NO_NODE) begin
                                n_tail[r_sel] = nn;
                            end
                        end
                        n_cur[r_sel]   = nn;
                        n_place[r_sel] = P_AT_NODE;
                        n_len[r_sel]   = l + LINK_BITS'(1);
                    end
                end
                OP_REMOVE: begin
                    if (l != '0 && pl == P_AT_NODE) begin
                        n_it = r_q_item;
                        n_iv = 1'b1;
                        if (l == LINK_BITS'(1)) begin
                            n_head[r_sel] = NO_NODE;
                            n_tail[r_sel] = NO_NODE;
                            n_cur[r_sel]  = NO_NODE;
                        end else if (c == h) begin
                            n_head[r_sel] = r;
                            n_cur[r_sel]  = r;
                            w2p_en        = (r != NO_NODE);
                            w2p_a         = r;
                            w2p_d         = NO_NODE;
                        end else if (c == t) begin
                            n_tail[r_sel] = p;
                            n_cur[r_sel]  = p;
                            w2n_en        = (p != NO_NODE);
                            w2n_a         = p;
                            w2n_d         = NO_NODE;
                        end else begin
                            w2n_en       = (p != NO_NODE);
                            w2n_a        = p;
                            w2n_d        = r;
                            w2p_en       = (r != NO_NODE);
                            w2p_a        = r;
                            w2p_d        = p;
                            n_cur[r_sel] = r;
                        end
                        if (c != NO_NODE) begin
                            w1n_en = 1'b1;
                            w1n_a  = c;
                            w1n_d  = r_free;
                            w1p_en = 1'b1;
                            w1p_a  = c;
                            w1p_d  = NO_NODE;
                            n_free = c;
                        end
                        n_place[r_sel] = P_AT_NODE;
                        n_len[r_sel]   = l - LINK_BITS'(1);
                    end
                end
                OP_JOIN: begin
                    if (r_sel != r_oth && r_len[r_oth] != '0) begin
                        if (l == '0) begin
                            n_head[r_sel]  = r_head[r_oth];
                            n_tail[r_sel]  = r_tail[r_oth];
                            n_cur[r_sel]   = r_cur[r_oth];
                            n_place[r_sel] = r_place[r_oth];
                            n_len[r_sel]   = r_len[r_oth];
                        end else begin
                            w1n_en        = (t != NO_NODE);
                            w1n_a         = t;
                            w1n_d         = r_head[r_oth];
                            w1p_en        = (r_head[r_oth] != NO_NODE);
                            w1p_a         = r_head[r_oth];
                            w1p_d         = t;
                            n_tail[r_sel] = r_tail[r_oth];
                            n_len[r_sel]  = l + r_len[r_oth];
                            if (pl == P_BEYOND_TAIL) begin
                                n_cur[r_sel] = r_tail[r_oth];
                            end
                        end
                        n_head[r_oth]  = NO_NODE;
                        n_tail[r_oth]  = NO_NODE;
                        n_cur[r_oth]   = NO_NODE;
                        n_len[r_oth]   = '0;
                        n_place[r_oth] = P_AT_NODE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        wn_en = 1'b0; wn_a = r_w2n_a; wn_d = r_w2n_d;
        wp_en = 1'b0; wp_a = r_w2p_a; wp_d = r_w2p_d;
        if (i_ctl.phase == PH_EX) begin
            wn_en = w1n_en; wn_a = w1n_a; wn_d = w1n_d;
            wp_en = w1p_en; wp_a = w1p_a; wp_d = w1p_d;
        end else if (i_ctl.phase == PH_W2) begin
            wn_en = r_w2n_en;
            wp_en = r_w2p_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wn_en) begin
            r_nx_mem[wn_a[NODE_BITS-1:0]] <= wn_d;
        end
        if (wp_en) begin
            r_pv_mem[wp_a[NODE_BITS-1:0]] <= wp_d;
        end
        if (w1i_en) begin
            r_it_mem[w1i_a[NODE_BITS-1:0]] <= r_item;
        end
        if (i_ctl.phase == PH_RD) begin
            r_q_nxa  <= r_nv[ca] ? r_nx_mem[ca] : LINK_BITS'(ca) + LINK_BITS'(1);
            r_q_nxb  <= r_nv[fb] ? r_nx_mem[fb] : LINK_BITS'(fb) + LINK_BITS'(1);
            r_q_pv   <= r_pv[ca] ? r_pv_mem[ca] : NO_NODE;
            r_q_item <= r_it_mem[ca];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= '0;
            r_pv <= '0;
        end else begin
            if (wn_en) begin
                r_nv[wn_a[NODE_BITS-1:0]] <= 1'b1;
            end
            if (wp_en) begin
                r_pv[wp_a[NODE_BITS-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LISTS; i++) begin
                r_head[i]  <= NO_NODE;
                r_tail[i]  <= NO_NODE;
                r_cur[i]   <= NO_NODE;
                r_len[i]   <= '0;
                r_place[i] <= P_AT_NODE;
            end
            r_free    <= '0;
            r_created <= '0;
            r_bad     <= 1'b0;
            r_mode    <= M_COUNT;
            r_w2n_en  <= 1'b0;
            r_w2p_en  <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_mode <= i_mode;
                r_bad  <= bad_in;
            end
            if (i_ctl.phase == PH_EX) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_cur     <= n_cur;
                r_len     <= n_len;
                r_place   <= n_place;
                r_free    <= n_free;
                r_created <= n_created;
                r_w2n_en  <= w2n_en;
                r_w2p_en  <= w2p_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_sel    <= i_list_sel;
            r_oth    <= i_other_list;
            r_item   <= ITEM_BITS'(i_item_in);
            r_it     <= '0;
            r_iv     <= 1'b0;
            r_status <= bad_in ? ST_NOLIST : ST_OK;
            r_newl   <= '0;
        end else if (i_ctl.phase == PH_EX) begin
            r_it     <= n_it;
            r_iv     <= n_iv;
            r_status <= n_status;
            r_newl   <= n_newl;
            r_w2n_a  <= w2n_a;
            r_w2n_d  <= w2n_d;
            r_w2p_a  <= w2p_a;
            r_w2p_d  <= w2p_d;
        end
        if (i_ctl.load_out) begin
            o_item_out   <= r_iv ? 32'(r_it) : 32'd0;
            o_item_valid <= r_iv;
            o_status     <= r_status;
            o_new_list   <= r_newl;
            if (r_bad || r_mode == M_CREATE) begin
                o_item_count   <= 7'd0;
                o_cursor_place <= P_AT_NODE;
            end else begin
                o_item_count   <= 7'(r_len[r_sel]);
                o_cursor_place <= r_place[r_sel];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cursor_list_pool_manager.sv -----
// ----------------------------------------------------------------------------
// cursor_list_pool_manager
// Several doubly linked lists with cursors that share one pool of nodes.
// ----------------------------------------------------------------------------
// A command transaction on the input channel carries a mode, a list, a second
// list for concat and an item handle. Each command yields exactly one result
// transaction on the output channel with the returned item, status, created
// list number, list length and cursor place.
// The block works on one command at a time. A command runs as a short
// program of operations, each in three phases (link memory read, execute
// with first write, second write), plus a start and a result phase.
// Count and rejected commands run no operation, most others one or two,
// and prepend three. The shared registered read ports of the node
// memories set this phase split.
// A finished result sits in the output register; the next command is taken
// while it waits. If the receiver stalls, the following command holds in its
// last phase until the output register is free.
// Reset is synchronous: the free chain, all lists and the count of
// created lists return to their initial values at once.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_list_pool_manager (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_mode,
    input  wire logic [1:0]  i_list_sel,
    input  wire logic [1:0]  i_other_list,
    input  wire logic [31:0] i_item_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_item_out,
    output logic             o_item_valid,
    output logic [1:0]       o_status,
    output logic [1:0]       o_new_list,
    output logic [6:0]       o_item_count,
    output logic [1:0]       o_cursor_place
);
    import clpm_pkg::*;

    t_ctl ctl;
    t_sts sts;

    clpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    clpm_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_mode         (i_mode),
        .i_list_sel     (i_list_sel),
        .i_other_list   (i_other_list),
        .i_item_in      (i_item_in),
        .o_item_out     (o_item_out),
        .o_item_valid   (o_item_valid),
        .o_status       (o_status),
        .o_new_list     (o_new_list),
        .o_item_count   (o_item_count),
        .o_cursor_place (o_cursor_place)
    );

endmodule

`default_nettype wire
